/* rtl/gji_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_pkg
// Shared widths, defaults and transfer bundles of the matrix inverter.
// ----------------------------------------------------------------------------
package gji_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 3;
  localparam int SIZE_W          = 4;
  localparam int DEF_MAX_ORDER   = 8;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // write request to both matrix memories
  typedef struct packed {
    logic              we_w;
    logic              we_i;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] wdata_w;
    logic [DATA_W-1:0] wdata_i;
  } mem_wr_t;

  // shared read address of both memories
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mem_rd_t;

  // one result transfer
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              singular;
    logic              overflowed;
    logic              is_last;
  } res_t;

endpackage
`default_nettype wire

/* rtl/gauss_jordan_matrix_inverter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gauss_jordan_matrix_inverter_unit
// Fixed-point n-by-n matrix inversion by Gauss-Jordan elimination with
// partial pivoting; elements in and inverse elements out, row-major.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  in_elem_value
//   out_     out  out_valid/out_stall inv_value, row/col_index, flags, is_last
//   cfg_     in   cfg_valid/cfg_ready cfg_matrix_size
//
// Loading writes one element per cycle into the work memory while in_stall
// is low. A full matrix then runs in the engine: for pivot i, search, swap,
// divide (one quotient bit a cycle) and elimination (read, multiply, round,
// write); output then streams the elements one at a time, each held while
// output stall is high. The serial divider dominates. rst_n is synchronous;
// input stalls while a job is queued or running or a size write is offered,
// and output stall holds the result.
// ----------------------------------------------------------------------------
module gauss_jordan_matrix_inverter_unit #(
  parameter int MAX_ORDER = gji_pkg::DEF_MAX_ORDER,
  parameter int FRAC_BITS = gji_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gji_pkg::DATA_W-1:0]  in_elem_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [gji_pkg::DATA_W-1:0]  out_inv_value,
  output logic      [gji_pkg::IDX_W-1:0]   out_row_index,
  output logic      [gji_pkg::IDX_W-1:0]   out_col_index,
  output logic                             out_singular,
  output logic                             out_overflowed,
  output logic                             out_is_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [gji_pkg::SIZE_W-1:0]  cfg_matrix_size
);

  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(CELLS);

  gji_pkg::mem_wr_t            ld_wr;
  gji_pkg::mem_wr_t            en_wr;
  gji_pkg::mem_wr_t            m_wr;
  gji_pkg::mem_rd_t            en_rd;
  gji_pkg::res_t               en_res;
  logic                        push;
  logic [gji_pkg::SIZE_W-1:0]  push_size;
  logic                        q_empty;
  logic [gji_pkg::SIZE_W-1:0]  q_head;
  logic                        pop;
  logic                        en_busy;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [gji_pkg::DATA_W-1:0]  rd_w;
  logic [gji_pkg::DATA_W-1:0]  rd_i;

  gji_loader #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_loader (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_elem_value   (in_elem_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_matrix_size (cfg_matrix_size),
    .hold            (!q_empty || en_busy),
    .push            (push),
    .push_size       (push_size),
    .wr              (ld_wr)
  );

  gji_fifo #(
    .WIDTH (gji_pkg::SIZE_W),
    .DEPTH (gji_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_size),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  gji_engine #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!q_empty),
    .job_size  (q_head),
    .job_pop   (pop),
    .busy      (en_busy),
    .rd        (en_rd),
    .rd_w      (rd_w),
    .rd_i      (rd_i),
    .wr        (en_wr),
    .res       (en_res),
    .out_stall (out_stall)
  );

  // loader writes only while the engine is idle
  assign m_wr  = (ld_wr.we_w || ld_wr.we_i) ? ld_wr : en_wr;
  assign waddr = AW'(int'(m_wr.row) * MAX_ORDER + int'(m_wr.col));
  assign raddr = AW'(int'(en_rd.row) * MAX_ORDER + int'(en_rd.col));

  gji_ram #(
    .WIDTH (gji_pkg::DATA_W),
    .DEPTH (CELLS)
  ) u_work_ram (
    .clk   (clk),
    .we    (m_wr.we_w),
    .waddr (waddr),
    .wdata (m_wr.wdata_w),
    .raddr (raddr),
    .rdata (rd_w)
  );

  gji_ram #(
    .WIDTH (gji_pkg::DATA_W),
    .DEPTH (CELLS)
  ) u_inv_ram (
    .clk   (clk),
    .we    (m_wr.we_i),
    .waddr (waddr),
    .wdata (m_wr.wdata_i),
    .raddr (raddr),
    .rdata (rd_i)
  );

  assign out_valid      = en_res.valid;
  assign out_inv_value  = en_res.value;
  assign out_row_index  = en_res.row;
  assign out_col_index  = en_res.col;
  assign out_singular   = en_res.singular;
  assign out_overflowed = en_res.overflowed;
  assign out_is_last    = en_res.is_last;

endmodule
`default_nettype wire

/* rtl/gji_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gji_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

/* rtl/gji_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_fifo
// Short job queue between the loader and the elimination engine.
// ----------------------------------------------------------------------------
module gji_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    rp_r;
  logic [CW-1:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !(pop && !empty)) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && pop && !empty) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/gji_loader.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_loader
// Front end: holds the order register, takes elements row-major, writes the
// work matrix and the identity alongside, and queues a job on the last one.
// ----------------------------------------------------------------------------
module gji_loader #(
  parameter int MAX_ORDER = gji_pkg::DEF_MAX_ORDER,
  parameter int FRAC_BITS = gji_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gji_pkg::DATA_W-1:0]  in_elem_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [gji_pkg::SIZE_W-1:0]  cfg_matrix_size,
  input  wire logic                        hold,
  output logic                             push,
  output logic      [gji_pkg::SIZE_W-1:0]  push_size,
  output gji_pkg::mem_wr_t                 wr
);

  localparam logic [gji_pkg::DATA_W-1:0] ONE = gji_pkg::DATA_W'(1) << FRAC_BITS;

  logic [gji_pkg::SIZE_W-1:0] size_r;
  logic [gji_pkg::IDX_W-1:0]  row_r;
  logic [gji_pkg::IDX_W-1:0]  col_r;
  logic [gji_pkg::SIZE_W-1:0] n_eff;
  logic [gji_pkg::IDX_W-1:0]  last;
  logic                       accept;

  always_comb begin
    n_eff = size_r;
    if (size_r == '0) begin
      n_eff = gji_pkg::SIZE_W'(1);
    end else if (size_r > gji_pkg::SIZE_W'(MAX_ORDER)) begin
      n_eff = gji_pkg::SIZE_W'(MAX_ORDER);
    end
  end

  assign last      = gji_pkg::IDX_W'(n_eff - gji_pkg::SIZE_W'(1));
  assign cfg_ready = 1'b1;
  // hold off elements while a size write is offered
  assign in_stall  = hold || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (row_r == last) && (col_r == last);
  assign push_size = n_eff;

  always_comb begin
    wr.we_w    = accept;
    wr.we_i    = accept;
    wr.row     = row_r;
    wr.col     = col_r;
    wr.wdata_w = in_elem_value;
    wr.wdata_i = (row_r == col_r) ? ONE : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= gji_pkg::SIZE_RESET;
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_valid) begin
      // drop any partial matrix
      size_r <= cfg_matrix_size;
      row_r  <= '0;
      col_r  <= '0;
    end else if (accept) begin
      if (col_r == last) begin
        col_r <= '0;
        row_r <= (row_r == last) ? '0 : row_r + gji_pkg::IDX_W'(1);
      end else begin
        col_r <= col_r + gji_pkg::IDX_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/gji_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_divider
// Restoring fixed-point divider, one quotient bit per cycle, rounding to
// nearest with ties away from zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module gji_divider #(
  parameter int FRAC_BITS = gji_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [gji_pkg::DATA_W-1:0]  num,
  input  wire logic [gji_pkg::DATA_W-1:0]  den,
  output logic                             done,
  output logic      [gji_pkg::DATA_W-1:0]  quot,
  output logic                             sat
);

  localparam int DW = gji_pkg::DATA_W + FRAC_BITS + 1;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]                 quo_r;
  logic [gji_pkg::DATA_W-1:0]    rem_r;
  logic [gji_pkg::DATA_W-1:0]    md_r;
  logic                          neg_r;
  logic [CW-1:0]                 cnt_r;
  logic                          busy_r;
  logic                          fin_r;
  logic                          done_r;
  logic [gji_pkg::DATA_W-1:0]    quot_r;
  logic                          sat_r;

  logic [gji_pkg::DATA_W-1:0]    mag_n;
  logic [gji_pkg::DATA_W-1:0]    mag_d;
  logic [DW-1:0]                 dvd;
  logic [gji_pkg::DATA_W:0]      rem_sh;
  logic                          ge;

  assign mag_n  = num[gji_pkg::DATA_W-1] ? (~num + 1'b1) : num;
  assign mag_d  = den[gji_pkg::DATA_W-1] ? (~den + 1'b1) : den;
  assign dvd    = DW'({mag_n, {FRAC_BITS{1'b0}}}) + DW'(mag_d >> 1);
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, md_r};

  assign done = done_r;
  assign quot = quot_r;
  assign sat  = sat_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dvd;
      rem_r <= '0;
      md_r  <= mag_d;
      neg_r <= num[gji_pkg::DATA_W-1] ^ den[gji_pkg::DATA_W-1];
    end else if (busy_r) begin
      rem_r <= gji_pkg::DATA_W'(ge ? (rem_sh - {1'b0, md_r}) : rem_sh);
      quo_r <= {quo_r[DW-2:0], ge};
    end
    if (fin_r) begin
      if (!neg_r) begin
        sat_r  <= |quo_r[DW-1:gji_pkg::DATA_W-1];
        quot_r <= (|quo_r[DW-1:gji_pkg::DATA_W-1]) ?
                  {1'b0, {(gji_pkg::DATA_W-1){1'b1}}} : quo_r[gji_pkg::DATA_W-1:0];
      end else if ((|quo_r[DW-1:gji_pkg::DATA_W]) ||
                   (quo_r[gji_pkg::DATA_W-1] && (|quo_r[gji_pkg::DATA_W-2:0]))) begin
        sat_r  <= 1'b1;
        quot_r <= {1'b1, {(gji_pkg::DATA_W-1){1'b0}}};
      end else begin
        sat_r  <= 1'b0;
        quot_r <= ~quo_r[gji_pkg::DATA_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/gji_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gji_engine
// Back end: pivot search, row swap, pivot row division, elimination and
// result streaming, sequenced over the two matrix memories.
// ----------------------------------------------------------------------------
module gji_engine #(
  parameter int MAX_ORDER = gji_pkg::DEF_MAX_ORDER,
  parameter int FRAC_BITS = gji_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        job_avail,
  input  wire logic [gji_pkg::SIZE_W-1:0]  job_size,
  output logic                             job_pop,
  output logic                             busy,
  output gji_pkg::mem_rd_t                 rd,
  input  wire logic [gji_pkg::DATA_W-1:0]  rd_w,
  input  wire logic [gji_pkg::DATA_W-1:0]  rd_i,
  output gji_pkg::mem_wr_t                 wr,
  output gji_pkg::res_t                    res,
  input  wire logic                        out_stall
);

  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DW = gji_pkg::DATA_W;
  localparam logic [DW-1:0] ONE  = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_SR_RD   = 18'b000000000000000010,
    S_SR_CMP  = 18'b000000000000000100,
    S_SW_RA   = 18'b000000000000001000,
    S_SW_RB   = 18'b000000000000010000,
    S_SW_WB   = 18'b000000000000100000,
    S_DV_WS   = 18'b000000000001000000,
    S_DV_WW   = 18'b000000000010000000,
    S_DV_IS   = 18'b000000000100000000,
    S_DV_IW   = 18'b000000001000000000,
    S_DV_WR   = 18'b000000010000000000,
    S_EL_C    = 18'b000000100000000000,
    S_EL_CW   = 18'b000001000000000000,
    S_EL_RD   = 18'b000010000000000000,
    S_EL_MUL  = 18'b000100000000000000,
    S_EL_RND  = 18'b001000000000000000,
    S_EL_WR   = 18'b010000000000000000,
    S_EM      = 18'b100000000000000000
  } state_t;

  typedef enum logic [2:0] {
    E_RD   = 3'b001,
    E_CAP  = 3'b010,
    E_HOLD = 3'b100
  } emit_t;

  state_t                      state_r;
  emit_t                       em_r;
  logic [gji_pkg::SIZE_W-1:0]  n_r;
  logic [gji_pkg::IDX_W-1:0]   i_r;
  logic [gji_pkg::IDX_W-1:0]   j_r;
  logic [gji_pkg::IDX_W-1:0]   k_r;
  logic [gji_pkg::IDX_W-1:0]   lead_r;
  logic [DW-1:0]               best_r;
  logic                        sing_r;
  logic                        ovf_r;
  logic                        sel_inv_r;
  logic [DW-1:0]               piv_r;
  logic [DW-1:0]               c_r;
  logic [DW-1:0]               old_r;
  logic [DW-1:0]               tmp_w_r;
  logic [DW-1:0]               tmp_i_r;
  logic signed [2*DW-1:0]      prod_r;
  logic [DW-1:0]               rnd_r;
  logic [DW-1:0]               pw_r [MAX_ORDER];
  logic [DW-1:0]               pi_r [MAX_ORDER];
  gji_pkg::res_t               res_r;

  logic [gji_pkg::IDX_W-1:0]   last;
  logic [KW-1:0]               kx;
  logic [DW-1:0]               mag;
  logic                        better;
  logic [DW-1:0]               best_n;
  logic [DW-1:0]               op;
  logic signed [2*DW:0]        rsum;
  logic signed [2*DW:0]        rsh;
  logic                        rnd_ok;
  logic [DW-1:0]               rnd_v;
  logic signed [DW:0]          diff;
  logic                        diff_ok;
  logic [DW-1:0]               diff_v;
  logic                        dv_start;
  logic [DW-1:0]               dv_num;
  logic                        dv_done;
  logic [DW-1:0]               dv_q;
  logic                        dv_sat;

  assign last    = gji_pkg::IDX_W'(n_r - gji_pkg::SIZE_W'(1));
  assign kx      = k_r[KW-1:0];
  assign busy    = (state_r != S_IDLE);
  assign job_pop = (state_r == S_IDLE) && job_avail;
  assign res     = res_r;

  assign mag    = rd_w[DW-1] ? (~rd_w + 1'b1) : rd_w;
  assign better = mag > best_r;
  assign best_n = better ? mag : best_r;

  assign op      = sel_inv_r ? pi_r[kx] : pw_r[kx];
  assign rsum    = (2*DW+1)'(prod_r) + ((2*DW+1)'(1) <<< (FRAC_BITS - 1));
  assign rsh     = rsum >>> FRAC_BITS;
  assign rnd_ok  = (&rsh[2*DW:DW-1]) || !(|rsh[2*DW:DW-1]);
  assign rnd_v   = rnd_ok ? rsh[DW-1:0] : (rsh[2*DW] ? SMIN : SMAX);
  assign diff    = $signed({old_r[DW-1], old_r}) - $signed({rnd_r[DW-1], rnd_r});
  assign diff_ok = (diff[DW] == diff[DW-1]);
  assign diff_v  = diff_ok ? diff[DW-1:0] : (diff[DW] ? SMIN : SMAX);

  assign dv_start = (state_r == S_DV_WS && k_r != i_r) || (state_r == S_DV_IS);
  assign dv_num   = (state_r == S_DV_IS) ? pi_r[kx] : pw_r[kx];

  gji_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (piv_r),
    .done  (dv_done),
    .quot  (dv_q),
    .sat   (dv_sat)
  );

  always_comb begin
    rd.row = j_r;
    rd.col = i_r;
    unique case (state_r)
      S_SW_RA: begin
        rd.row = i_r;
        rd.col = k_r;
      end
      S_SW_RB: begin
        rd.row = lead_r;
        rd.col = k_r;
      end
      S_EL_RD, S_EM: begin
        rd.row = j_r;
        rd.col = k_r;
      end
      default: begin
        rd.row = j_r;
        rd.col = i_r;
      end
    endcase
  end

  always_comb begin
    wr.we_w    = 1'b0;
    wr.we_i    = 1'b0;
    wr.row     = i_r;
    wr.col     = k_r;
    wr.wdata_w = pw_r[kx];
    wr.wdata_i = pi_r[kx];
    unique case (state_r)
      S_SW_WB: begin
        wr.we_w    = 1'b1;
        wr.we_i    = 1'b1;
        wr.row     = lead_r;
        wr.wdata_w = tmp_w_r;
        wr.wdata_i = tmp_i_r;
      end
      S_DV_WR: begin
        wr.we_w = 1'b1;
        wr.we_i = 1'b1;
      end
      S_EL_WR: begin
        wr.we_w    = !sel_inv_r;
        wr.we_i    = sel_inv_r;
        wr.row     = j_r;
        wr.wdata_w = diff_v;
        wr.wdata_i = diff_v;
      end
      default: begin
        wr.we_w = 1'b0;
        wr.we_i = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      em_r        <= E_RD;
      res_r.valid <= 1'b0;
      sing_r      <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_avail) begin
            n_r     <= job_size;
            i_r     <= '0;
            j_r     <= '0;
            lead_r  <= '0;
            best_r  <= '0;
            sing_r  <= 1'b0;
            ovf_r   <= 1'b0;
            state_r <= S_SR_RD;
          end
        end
        S_SR_RD: begin
          state_r <= S_SR_CMP;
        end
        S_SR_CMP: begin
          best_r <= best_n;
          if (better) begin
            lead_r <= j_r;
          end
          if (j_r == last) begin
            k_r <= '0;
            if (best_n == '0) begin
              sing_r  <= 1'b1;
              j_r     <= '0;
              em_r    <= E_RD;
              state_r <= S_EM;
            end else begin
              state_r <= S_SW_RA;
            end
          end else begin
            j_r     <= j_r + gji_pkg::IDX_W'(1);
            state_r <= S_SR_RD;
          end
        end
        S_SW_RA: begin
          state_r <= S_SW_RB;
        end
        S_SW_RB: begin
          tmp_w_r <= rd_w;
          tmp_i_r <= rd_i;
          state_r <= S_SW_WB;
        end
        S_SW_WB: begin
          // pivot row lands in the row buffer, row i moves to the lead slot
          pw_r[kx] <= rd_w;
          pi_r[kx] <= rd_i;
          if (k_r == i_r) begin
            piv_r <= rd_w;
          end
          if (k_r == last) begin
            k_r     <= '0;
            state_r <= S_DV_WS;
          end else begin
            k_r     <= k_r + gji_pkg::IDX_W'(1);
            state_r <= S_SW_RA;
          end
        end
        S_DV_WS: begin
          if (k_r == i_r) begin
            pw_r[kx] <= ONE;
            state_r  <= S_DV_IS;
          end else begin
            state_r <= S_DV_WW;
          end
        end
        S_DV_WW: begin
          if (dv_done) begin
            pw_r[kx] <= dv_q;
            ovf_r    <= ovf_r | dv_sat;
            state_r  <= S_DV_IS;
          end
        end
        S_DV_IS: begin
          state_r <= S_DV_IW;
        end
        S_DV_IW: begin
          if (dv_done) begin
            pi_r[kx] <= dv_q;
            ovf_r    <= ovf_r | dv_sat;
            state_r  <= S_DV_WR;
          end
        end
        S_DV_WR: begin
          if (k_r == last) begin
            j_r     <= '0;
            state_r <= S_EL_C;
          end else begin
            k_r     <= k_r + gji_pkg::IDX_W'(1);
            state_r <= S_DV_WS;
          end
        end
        S_EL_C: begin
          if (j_r == i_r) begin
            if (j_r == last) begin
              if (i_r == last) begin
                j_r     <= '0;
                k_r     <= '0;
                em_r    <= E_RD;
                state_r <= S_EM;
              end else begin
                i_r     <= i_r + gji_pkg::IDX_W'(1);
                j_r     <= i_r + gji_pkg::IDX_W'(1);
                lead_r  <= i_r + gji_pkg::IDX_W'(1);
                best_r  <= '0;
                state_r <= S_SR_RD;
              end
            end else begin
              j_r <= j_r + gji_pkg::IDX_W'(1);
            end
          end else begin
            state_r <= S_EL_CW;
          end
        end
        S_EL_CW: begin
          c_r       <= rd_w;
          k_r       <= i_r;
          sel_inv_r <= 1'b0;
          state_r   <= S_EL_RD;
        end
        S_EL_RD: begin
          state_r <= S_EL_MUL;
        end
        S_EL_MUL: begin
          old_r   <= sel_inv_r ? rd_i : rd_w;
          prod_r  <= $signed(op) * $signed(c_r);
          state_r <= S_EL_RND;
        end
        S_EL_RND: begin
          rnd_r   <= rnd_v;
          ovf_r   <= ovf_r | !rnd_ok;
          state_r <= S_EL_WR;
        end
        S_EL_WR: begin
          ovf_r <= ovf_r | !diff_ok;
          if (k_r != last) begin
            k_r     <= k_r + gji_pkg::IDX_W'(1);
            state_r <= S_EL_RD;
          end else if (!sel_inv_r) begin
            sel_inv_r <= 1'b1;
            k_r       <= '0;
            state_r   <= S_EL_RD;
          end else if (j_r == last) begin
            if (i_r == last) begin
              j_r     <= '0;
              k_r     <= '0;
              em_r    <= E_RD;
              state_r <= S_EM;
            end else begin
              i_r     <= i_r + gji_pkg::IDX_W'(1);
              j_r     <= i_r + gji_pkg::IDX_W'(1);
              lead_r  <= i_r + gji_pkg::IDX_W'(1);
              best_r  <= '0;
              state_r <= S_SR_RD;
            end
          end else begin
            j_r     <= j_r + gji_pkg::IDX_W'(1);
            state_r <= S_EL_C;
          end
        end
        S_EM: begin
          unique case (em_r)
            E_RD: begin
              em_r <= E_CAP;
            end
            E_CAP: begin
              res_r.valid      <= 1'b1;
              res_r.value      <= rd_i;
              res_r.row        <= j_r;
              res_r.col        <= k_r;
              res_r.singular   <= sing_r;
              res_r.overflowed <= ovf_r;
              res_r.is_last    <= (j_r == last) && (k_r == last);
              em_r             <= E_HOLD;
            end
            E_HOLD: begin
              // hold the result until the transfer completes
              if (!out_stall) begin
                res_r.valid <= 1'b0;
                em_r        <= E_RD;
                if (k_r == last) begin
                  k_r <= '0;
                  if (j_r == last) begin
                    state_r <= S_IDLE;
                  end else begin
                    j_r <= j_r + gji_pkg::IDX_W'(1);
                  end
                end else begin
                  k_r <= k_r + gji_pkg::IDX_W'(1);
                end
              end
            end
            default: begin
              em_r <= E_RD;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* test/tb_gauss_jordan_matrix_inverter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gauss_jordan_matrix_inverter_unit
// Loads fixed-point matrices of every supported order into the inverter and
// checks each inverse element, its position and its flags against a
// scoreboard that runs a partial-pivoting elimination in software.
// ----------------------------------------------------------------------------
module tb_gauss_jordan_matrix_inverter_unit;

  localparam int DATA_W = gji_pkg::DATA_W;
  localparam int IDX_W  = gji_pkg::IDX_W;
  localparam int SIZE_W = gji_pkg::SIZE_W;
  localparam int MAXN   = gji_pkg::DEF_MAX_ORDER;
  localparam int FRAC   = gji_pkg::DEF_FRAC_BITS;
  localparam int ONE    = 1 << FRAC;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              singular;
    logic              overflowed;
    logic              is_last;
  } inv_elem_t;

  class inverse_scoreboard;
    logic [SIZE_W-1:0] size_reg;
    int                work[MAXN*MAXN];
    int                inv[MAXN*MAXN];
    int                load_cnt;
    bit                sing, ovf;
    inv_elem_t         pending_q[$];
    int                errors, checked, matrices;

    function new();
      size_reg = gji_pkg::SIZE_RESET;
      load_cnt = 0;
      sing = 0;
      ovf = 0;
      errors = 0;
      checked = 0;
      matrices = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function int order_n();
      int n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > MAXN) n = MAXN;
      return n;
    endfunction

    function int sat(longint v);
      if (v > longint'(32'sh7fffffff)) begin
        ovf = 1;
        return 32'sh7fffffff;
      end
      if (v < -longint'(64'sh80000000)) begin
        ovf = 1;
        return 32'sh80000000;
      end
      return int'(v);
    endfunction

    function int mul_q(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
      return sat(p >>> FRAC);
    endfunction

    function int sub_q(int a, int b);
      return sat(longint'(a) - longint'(b));
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    function int div_q(int num, int den);
      longint          wide, r;
      longint unsigned mn, md, q;
      wide = longint'(num) * (longint'(1) <<< FRAC);
      mn = mag(wide);
      md = mag(longint'(den));
      q = (mn + md / 2) / md;
      r = longint'(q);
      if ((wide < 0) != (den < 0)) r = -r;
      return sat(r);
    endfunction

    function void eliminate(int n);
      int               lead, piv, c, t;
      longint unsigned  best, m;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          inv[i*MAXN+j] = (i == j) ? ONE : 0;
      for (int i = 0; i < n; i++) begin
        lead = i;
        best = mag(longint'(work[i*MAXN+i]));
        for (int j = i + 1; j < n; j++) begin
          m = mag(longint'(work[j*MAXN+i]));
          if (m > best) begin
            best = m;
            lead = j;
          end
        end
        if (best == 0) begin
          sing = 1;
          return;
        end
        if (lead != i) begin
          for (int k = 0; k < n; k++) begin
            t = work[i*MAXN+k]; work[i*MAXN+k] = work[lead*MAXN+k]; work[lead*MAXN+k] = t;
            t = inv[i*MAXN+k]; inv[i*MAXN+k] = inv[lead*MAXN+k]; inv[lead*MAXN+k] = t;
          end
        end
        piv = work[i*MAXN+i];
        for (int k = 0; k < n; k++) begin
          if (k != i) work[i*MAXN+k] = div_q(work[i*MAXN+k], piv);
          inv[i*MAXN+k] = div_q(inv[i*MAXN+k], piv);
        end
        work[i*MAXN+i] = ONE;
        for (int j = 0; j < n; j++) begin
          if (j == i) continue;
          c = work[j*MAXN+i];
          for (int k = i; k < n; k++)
            work[j*MAXN+k] = sub_q(work[j*MAXN+k], mul_q(work[i*MAXN+k], c));
          for (int k = 0; k < n; k++)
            inv[j*MAXN+k] = sub_q(inv[j*MAXN+k], mul_q(inv[i*MAXN+k], c));
        end
      end
    endfunction

    function void write_size(logic [SIZE_W-1:0] v);
      size_reg = v;
      load_cnt = 0;
    endfunction

    // note one accepted element; a completed matrix queues its whole inverse
    function void note_elem(logic [DATA_W-1:0] v);
      int        n, total;
      inv_elem_t e;
      n = order_n();
      total = n * n;
      if (load_cnt >= total) load_cnt = 0;
      if (load_cnt == 0) begin
        sing = 0;
        ovf = 0;
      end
      work[(load_cnt / n)*MAXN + load_cnt % n] = int'(v);
      load_cnt++;
      if (load_cnt < total) return;
      load_cnt = 0;
      matrices++;
      eliminate(n);
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          e.value = inv[r*MAXN+c];
          e.row = IDX_W'(r);
          e.col = IDX_W'(c);
          e.singular = sing;
          e.overflowed = ovf;
          e.is_last = (r*n + c + 1 == total);
          pending_q.push_back(e);
        end
    endfunction

    task check_elem(inv_elem_t got);
      inv_elem_t x;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result r%0d c%0d", got.row, got.col));
        return;
      end
      x = pending_q.pop_front();
      checked++;
      if (got.value !== x.value)
        report($sformatf("value r%0d c%0d: got %h exp %h", x.row, x.col, got.value, x.value));
      if (got.row !== x.row || got.col !== x.col)
        report($sformatf("index: got r%0d c%0d exp r%0d c%0d", got.row, got.col, x.row, x.col));
      if (got.singular !== x.singular)
        report($sformatf("singular r%0d c%0d: got %b", x.row, x.col, got.singular));
      if (got.overflowed !== x.overflowed)
        report($sformatf("overflowed r%0d c%0d: got %b", x.row, x.col, got.overflowed));
      if (got.is_last !== x.is_last)
        report($sformatf("is_last r%0d c%0d: got %b", x.row, x.col, got.is_last));
    endtask
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_stall;
  logic [DATA_W-1:0] in_elem_value = '0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [DATA_W-1:0] out_inv_value;
  logic [IDX_W-1:0]  out_row_index, out_col_index;
  logic              out_singular, out_overflowed, out_is_last;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_matrix_size = '0;

  inverse_scoreboard sb = new();
  int gap_pct = 0;
  int stall_pct = 0;
  int elems_sent = 0;

  gauss_jordan_matrix_inverter_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_inv_value(out_inv_value),
    .out_row_index(out_row_index), .out_col_index(out_col_index),
    .out_singular(out_singular), .out_overflowed(out_overflowed),
    .out_is_last(out_is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_matrix_size(cfg_matrix_size)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    inv_elem_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.value = out_inv_value;
      got.row = out_row_index;
      got.col = out_col_index;
      got.singular = out_singular;
      got.overflowed = out_overflowed;
      got.is_last = out_is_last;
      sb.check_elem(got);
    end
  end

  task send_elem(logic [DATA_W-1:0] v);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_elem_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_elem(v);
    elems_sent++;
  endtask

  // hold until every inverse element is out, then let the engine settle
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_size(int v);
    drain();
    cfg_valid <= 1;
    cfg_matrix_size <= SIZE_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_size(SIZE_W'(v));
  endtask

  function logic [DATA_W-1:0] rand_elem(int style, int r, int c);
    int v;
    case (style)
      0: v = $urandom();
      1: v = ($urandom_range(2) == 0) ? 0 : $urandom_range(2*ONE) - ONE;
      default: begin
        v = $urandom_range(4*ONE) - 2*ONE;
        if (r == c) v = ($urandom_range(1) ? 1 : -1) * ($urandom_range(12*ONE) + 4*ONE);
      end
    endcase
    return v;
  endfunction

  task send_matrix(int n);
    int style, k;
    k = $urandom_range(99);
    style = (k < 12) ? 0 : (k < 24) ? 1 : 2;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send_elem(rand_elem(style, r, c));
  endtask

  initial begin
    int sizes[12];
    int n, mats;
    sizes = '{3, 2, 4, 1, 5, 8, 2, 6, 3, 7, 15, 4};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // one-by-one matrices: zero pivot, extremes, unit values
    write_size(1);
    send_elem(0);
    send_elem(32'h7fffffff);
    send_elem(32'h80000000);
    send_elem(1);
    send_elem(32'hffffffff);
    // order zero behaves as one
    write_size(0);
    send_elem(2 * ONE);
    // swap needed, then singular after elimination, then tied magnitudes
    write_size(2);
    send_elem(0); send_elem(ONE); send_elem(ONE); send_elem(0);
    send_elem(ONE); send_elem(2*ONE); send_elem(2*ONE); send_elem(4*ONE);
    send_elem(ONE); send_elem(ONE); send_elem(-ONE); send_elem(ONE);
    // partial load dropped by a size write
    write_size(3);
    send_elem(ONE); send_elem(5); send_elem(32'h80000000); send_elem(7);
    write_size(3);

    foreach (sizes[i]) begin
      if (i < 4) begin
        gap_pct = 29;
        stall_pct = 57;
      end else if (i < 8) begin
        gap_pct = 57;
        stall_pct = 29;
      end else begin
        gap_pct = 0;
        stall_pct = 0;
      end
      write_size(sizes[i]);
      n = sb.order_n();
      mats = (18 / (n * n) > 1) ? 18 / (n * n) : 1;
      repeat (mats) send_matrix(n);
    end

    drain();
    $display("Sent %0d elements forming %0d matrices of orders 1 to 8,", elems_sent,
             sb.matrices);
    $display("checked %0d inverse elements with sender and receiver idling.", sb.checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Timeout with %0d inverse elements outstanding", sb.pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gji_pkg.sv
rtl/gji_ram.sv
rtl/gji_fifo.sv
rtl/gji_loader.sv
rtl/gji_divider.sv
rtl/gji_engine.sv
rtl/gauss_jordan_matrix_inverter_unit.sv
test/tb_gauss_jordan_matrix_inverter_unit.sv
